// ===== hdl/hsv2rgb_pkg.sv =====
// shared constants and types for the hsv to rgb pixel converter
`timescale 1ns / 1ps

package hsv2rgb_pkg;

    // input reduction
    localparam logic [8:0] HUE_MOD    = 9'd360;
    localparam logic [6:0] PCT_MOD    = 7'd101;
    localparam logic [6:0] PCT_ONE    = 7'd100;
    localparam logic [5:0] SECTOR_DEG = 6'd60;

    // internal widths
    localparam int HUE_W   = 9;
    localparam int PCT_W   = 7;
    localparam int PROD_W  = 14;   // v*s and 100*v, at most 10000
    localparam int LEVEL_W = 20;   // levels in 1/600000 units, at most 600000
    localparam int CHAN_W  = 8;

    // 255/600000 = 17/40000 = 17 / (64 * 625)
    localparam int          LEVEL_MUL_W = 24;   // 17 * 600000 fits in 24 bits
    localparam logic [4:0]  LEVEL_MUL   = 5'd17;
    localparam int          DIV64_SH    = 6;
    localparam int          Y_W         = LEVEL_MUL_W - DIV64_SH;   // 18 bits
    // floor(y/625) = (y * ceil(2^28/625)) >> 28, exact for y < 2^18
    localparam int                 RECIP_W  = 19;
    localparam logic [RECIP_W-1:0] RECIP_K  = 19'd429497;
    localparam int                 RECIP_SH = 28;
    localparam int                 QPROD_W  = 36;

    // hue sector, h/60
    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } sector_t;

    // load enables for the two scaler stages
    typedef struct packed {
        logic load_y;
        logic load_q;
    } scale_en_t;

endpackage

// ===== hdl/hsv2rgb_chan_scale.sv =====
// two-stage scaler: channel = floor(255 * level / 600000)
`timescale 1ns / 1ps

module hsv2rgb_chan_scale
    import hsv2rgb_pkg::*;
(
    input  logic                 aclk,
    input  scale_en_t            en,
    input  logic [LEVEL_W-1:0]   level,
    output logic [CHAN_W-1:0]    chan
);

    logic [LEVEL_MUL_W-1:0] mul17;
    logic [Y_W-1:0]         y_reg;
    logic [Y_W-1:0]         y_next;
    logic [QPROD_W-1:0]     qprod;
    logic [CHAN_W-1:0]      chan_reg;
    logic [CHAN_W-1:0]      chan_next;

    // 17 * level, then drop the factor of 64
    assign mul17  = LEVEL_MUL_W'(level) * LEVEL_MUL_W'(LEVEL_MUL);
    assign y_next = mul17[LEVEL_MUL_W-1:DIV64_SH];

    // divide by 625 through the reciprocal
    assign qprod     = QPROD_W'(y_reg) * QPROD_W'(RECIP_K);
    assign chan_next = qprod[RECIP_SH+CHAN_W-1:RECIP_SH];

    always_ff @(posedge aclk) begin
        if (en.load_y) begin
            y_reg <= y_next;
        end
        if (en.load_q) begin
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

// ===== hdl/hsv_to_rgb_pixel.sv =====
// top level: hsv to 8-bit rgb pixel converter, five-stage pipeline
`timescale 1ns / 1ps

// Takes one HSV pixel per beat (hue in degrees, wrapped modulo 360;
// saturation and brightness in percent, wrapped modulo 101 so 101 reads as 0)
// and returns one RGB pixel per beat, each channel floor(255 * level) with the
// level computed exactly in integers, no rounding before the final floor.
// Five register stages: input wrap, chroma multiply and sector decode, level
// forming, scale by 17/64, divide by 625 via reciprocal multiply. A beat
// accepted passes the stages in order to m_tdata, leaving with m_tready high;
// one pixel is taken every cycle unless a stall on m_tready fills the stages.
// Each stage has its own valid bit and advances when the stage after it is
// empty or moving, so a stall on m_tready holds everything in place and
// bubbles are squeezed out.

module hsv_to_rgb_pixel
    import hsv2rgb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input pixel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // hue[8:0], saturation[15:9], brightness[22:16], zero[23]
    // output pixel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata     // red[7:0], green[15:8], blue[23:16]
);

    localparam int NSTAGE = 5;

    // unpacked input fields
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] saturation;
    logic [PCT_W-1:0] brightness;

    assign hue        = s_tdata[8:0];
    assign saturation = s_tdata[15:9];
    assign brightness = s_tdata[22:16];

    // stage valid bits and ready chain
    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] vld_next;
    logic [NSTAGE-1:0] adv;

    always_comb begin
        adv[NSTAGE-1] = !vld_reg[NSTAGE-1] || m_tready;
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    always_comb begin
        vld_next = vld_reg;
        if (adv[0]) begin
            vld_next[0] = s_tvalid;
        end
        for (int i = 1; i < NSTAGE; i++) begin
            if (adv[i]) begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = vld_reg[NSTAGE-1];

    // ---------------- stage 1: wrap inputs ----------------
    logic [HUE_W-1:0] h1_reg, h1_next;
    logic [PCT_W-1:0] s1_reg, s1_next;
    logic [PCT_W-1:0] v1_reg, v1_next;

    assign h1_next = (hue >= HUE_MOD) ? hue - HUE_MOD : hue;
    assign s1_next = (saturation >= PCT_MOD) ? saturation - PCT_MOD : saturation;
    assign v1_next = (brightness >= PCT_MOD) ? brightness - PCT_MOD : brightness;

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            h1_reg <= h1_next;
            s1_reg <= s1_next;
            v1_reg <= v1_next;
        end
    end

    // ---------------- stage 2: chroma, 100*v, sector, ramp ----------------
    logic [PROD_W-1:0] c2_reg, c2_next;
    logic [PROD_W-1:0] v100_2_reg, v100_2_next;
    sector_t           sec2_reg, sec2_next;
    logic [5:0]        t2_reg, t2_next;
    logic [5:0]        ofs;     // position inside the sector, 0..59

    assign c2_next     = PROD_W'(v1_reg) * PROD_W'(s1_reg);
    assign v100_2_next = PROD_W'(v1_reg) * PROD_W'(PCT_ONE);

    always_comb begin
        priority if (h1_reg >= HUE_W'(300)) begin
            sec2_next = SEC_5;
            ofs       = 6'(h1_reg - HUE_W'(300));
        end else if (h1_reg >= HUE_W'(240)) begin
            sec2_next = SEC_4;
            ofs       = 6'(h1_reg - HUE_W'(240));
        end else if (h1_reg >= HUE_W'(180)) begin
            sec2_next = SEC_3;
            ofs       = 6'(h1_reg - HUE_W'(180));
        end else if (h1_reg >= HUE_W'(120)) begin
            sec2_next = SEC_2;
            ofs       = 6'(h1_reg - HUE_W'(120));
        end else if (h1_reg >= HUE_W'(60)) begin
            sec2_next = SEC_1;
            ofs       = 6'(h1_reg - HUE_W'(60));
        end else begin
            sec2_next = SEC_0;
            ofs       = 6'(h1_reg);
        end
    end

    // rising ramp in even sectors, falling in odd ones
    assign t2_next = sec2_next[0] ? SECTOR_DEG - ofs : ofs;

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            c2_reg     <= c2_next;
            v100_2_reg <= v100_2_next;
            sec2_reg   <= sec2_next;
            t2_reg     <= t2_next;
        end
    end

    // ---------------- stage 3: levels in 1/600000 units ----------------
    logic [PROD_W-1:0]  m3;
    logic [LEVEL_W-1:0] lm3;
    logic [LEVEL_W-1:0] lc3_reg, lc3_next;
    logic [LEVEL_W-1:0] lx3_reg, lx3_next;
    logic [LEVEL_W-1:0] lm3_reg;
    sector_t            sec3_reg;

    assign m3       = v100_2_reg - c2_reg;
    assign lm3      = LEVEL_W'(m3) * LEVEL_W'(SECTOR_DEG);
    assign lc3_next = LEVEL_W'(v100_2_reg) * LEVEL_W'(SECTOR_DEG);   // 60*(c+m)
    assign lx3_next = LEVEL_W'(c2_reg) * LEVEL_W'(t2_reg) + lm3;

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            lc3_reg  <= lc3_next;
            lx3_reg  <= lx3_next;
            lm3_reg  <= lm3;
            sec3_reg <= sec2_reg;
        end
    end

    // ---------------- stages 4-5: channel order and scaling ----------------
    logic [LEVEL_W-1:0] lvl_r, lvl_g, lvl_b;

    always_comb begin
        unique case (sec3_reg)
            SEC_0: begin
                lvl_r = lc3_reg; lvl_g = lx3_reg; lvl_b = lm3_reg;
            end
            SEC_1: begin
                lvl_r = lx3_reg; lvl_g = lc3_reg; lvl_b = lm3_reg;
            end
            SEC_2: begin
                lvl_r = lm3_reg; lvl_g = lc3_reg; lvl_b = lx3_reg;
            end
            SEC_3: begin
                lvl_r = lm3_reg; lvl_g = lx3_reg; lvl_b = lc3_reg;
            end
            SEC_4: begin
                lvl_r = lx3_reg; lvl_g = lm3_reg; lvl_b = lc3_reg;
            end
            default: begin
                lvl_r = lc3_reg; lvl_g = lm3_reg; lvl_b = lx3_reg;
            end
        endcase
    end

    scale_en_t          sc_en;
    logic [CHAN_W-1:0]  red, green, blue;

    assign sc_en.load_y = adv[3];
    assign sc_en.load_q = adv[4];

    hsv2rgb_chan_scale u_scale_r (
        .aclk  (aclk),
        .en    (sc_en),
        .level (lvl_r),
        .chan  (red)
    );

    hsv2rgb_chan_scale u_scale_g (
        .aclk  (aclk),
        .en    (sc_en),
        .level (lvl_g),
        .chan  (green)
    );

    hsv2rgb_chan_scale u_scale_b (
        .aclk  (aclk),
        .en    (sc_en),
        .level (lvl_b),
        .chan  (blue)
    );

    assign m_tdata = {blue, green, red};

endmodule
